[hw/rtl/ellipsoid_horizon_quad_unit_defines.svh]
// assertion macros used by the checker file
`ifndef ELLIPSOID_HORIZON_QUAD_UNIT_DEFINES_SVH
`define ELLIPSOID_HORIZON_QUAD_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define EHQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ehq: implication failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define EHQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ehq: next-cycle implication failed");

`endif

[hw/rtl/ehq_pkg.sv]
`default_nettype none

package ehq_pkg;

  localparam int POS_W       = 48;
  localparam int RAD_W       = 36;
  localparam int UNIT_FRAC   = 30;
  localparam int NORM_W      = 64;                 // fraction bits of the scaled position
  localparam int Q_W         = POS_W + NORM_W;     // width of a scaled position
  localparam int V_W         = 62;                 // normalized component width
  localparam int HALF_W      = V_W / 2;
  localparam int LIM_OFFS    = 2 * V_W + 2;        // exponent of one unit of u
  localparam int BL_W        = 7;
  localparam int CHUNK_W     = 16;
  localparam int CHUNKS      = Q_W / CHUNK_W;
  localparam int POS_IDX_W   = $clog2(CHUNK_W);
  localparam int DIV_W       = 128;
  localparam int DEN_W       = 64;
  localparam int DIV_LAT     = DIV_W;
  localparam int SQ_W        = 128;
  localparam int ROOT_W      = 64;
  localparam int SQRT_LAT    = ROOT_W;
  localparam int UNIT_W      = 36;
  localparam int K_W         = UNIT_W + 2;
  localparam int ITEM_CYCLES = 4;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Z = 2'd2;

  localparam logic [RAD_W-1:0] RADIUS_X_RST = RAD_W'(64'd6378137000);
  localparam logic [RAD_W-1:0] RADIUS_Y_RST = RAD_W'(64'd6378137000);
  localparam logic [RAD_W-1:0] RADIUS_Z_RST = RAD_W'(64'd6356752314);

  typedef enum logic [1:0] {
    ST_VALID  = 2'd0,
    ST_INSIDE = 2'd1,
    ST_POLAR  = 2'd2
  } status_t;

  typedef logic signed [UNIT_W-1:0] unit_t;

  typedef struct packed {
    logic signed [POS_W-1:0] camera_x;
    logic signed [POS_W-1:0] camera_y;
    logic signed [POS_W-1:0] camera_z;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]              corner;
    logic signed [POS_W-1:0] vertex_x;
    logic signed [POS_W-1:0] vertex_y;
    logic signed [POS_W-1:0] vertex_z;
    status_t                 status;
    logic                    last;
  } out_beat_t;

  // signed fixed-point product, magnitude truncated
  function automatic unit_t qmul(unit_t x, unit_t y);
    logic [UNIT_W-1:0]   mx;
    logic [UNIT_W-1:0]   my;
    logic [2*UNIT_W-1:0] p;
    logic [UNIT_W-1:0]   m;
    mx = x[UNIT_W-1] ? UNIT_W'(-x) : UNIT_W'(x);
    my = y[UNIT_W-1] ? UNIT_W'(-y) : UNIT_W'(y);
    p  = {{UNIT_W{1'b0}}, mx} * {{UNIT_W{1'b0}}, my};
    m  = p[UNIT_FRAC +: UNIT_W];
    return (x[UNIT_W-1] ^ y[UNIT_W-1]) ? -signed'(m) : signed'(m);
  endfunction

  // quotient magnitude with sign applied
  function automatic unit_t to_unit(logic [DIV_W-1:0] q, logic neg);
    logic [UNIT_W-1:0] m;
    m = {1'b0, q[UNIT_W-2:0]};
    return neg ? -signed'(m) : signed'(m);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ellipsoid_horizon_quad_unit.sv]
`default_nettype none

// channel  | ports                               | beat
// ---------+-------------------------------------+---------------------------------
// input    | start, busy, in_data                | one camera position (x, y, z)
// result   | out_valid, out_data                 | one quad corner, status, last
// config   | cfg_we, cfg_index, cfg_wdata        | one radius register write
//
// an item is taken when start is high and busy is low; busy then stays high until the
// cool-down counter cool_r runs back to zero, and only then can the next item enter
// first result beat comes out after two chains of 128 one-bit divider stages and one
// chain of 64 square-root stages; earlier items may still be in flight when one is taken
// a valid item gives four consecutive beats, an inside or polar item one beat
// rst_n is synchronous, active low; it clears valid bits and restores the radii
// results are never held off: each beat stands on the outputs for one cycle

module ellipsoid_horizon_quad_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  ehq_pkg::in_beat_t                   in_data,
  output logic                                out_valid,
  output ehq_pkg::out_beat_t                  out_data,
  input  logic                                cfg_we,
  input  logic [ehq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ehq_pkg::RAD_W-1:0]           cfg_wdata
);
  import ehq_pkg::*;

  localparam int COOL_W = $clog2(ITEM_CYCLES);

  // ---------------------------------------------------------------- config
  logic [RAD_W-1:0] rad_r [3];
  logic [RAD_W-1:0] reff  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r[0] <= RADIUS_X_RST;
      rad_r[1] <= RADIUS_Y_RST;
      rad_r[2] <= RADIUS_Z_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS_X: rad_r[0] <= cfg_wdata;
        REG_RADIUS_Y: rad_r[1] <= cfg_wdata;
        REG_RADIUS_Z: rad_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a zero radius acts as one
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      reff[i] = (rad_r[i] == '0) ? RAD_W'(1) : rad_r[i];
    end
  end

  // ---------------------------------------------------------------- intake
  logic              in_fire;
  logic [COOL_W-1:0] cool_r;
  logic [COOL_W-1:0] cool_nxt;

  assign in_fire = start && !busy;
  assign busy    = cool_r != '0;

  always_comb begin
    if (in_fire) begin
      cool_nxt = COOL_W'(ITEM_CYCLES - 1);
    end else if (cool_r != '0) begin
      cool_nxt = cool_r - 1'b1;
    end else begin
      cool_nxt = cool_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cool_r <= '0;
    end else begin
      cool_r <= cool_nxt;
    end
  end

  // stage 0: sign and magnitude of each coordinate
  logic                  val0_r;
  logic [2:0]            neg0_r;
  logic [2:0][POS_W-1:0] mag0_r;
  logic [2:0][POS_W-1:0] raw;

  assign raw[0] = in_data.camera_x;
  assign raw[1] = in_data.camera_y;
  assign raw[2] = in_data.camera_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val0_r <= 1'b0;
    end else begin
      val0_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      neg0_r[i] <= raw[i][POS_W-1];
      mag0_r[i] <= raw[i][POS_W-1] ? (~raw[i] + 1'b1) : raw[i];
    end
  end

  // ---------------------------------------------------------------- scale to unit sphere
  // q = |p| * 2^64 / r, three dividers side by side
  logic [DIV_W-1:0] qa [3];

  for (genvar a = 0; a < 3; a++) begin : g_scale
    ehq_div u_div (
      .clk (clk),
      .num (DIV_W'({mag0_r[a], {NORM_W{1'b0}}})),
      .den (DEN_W'(reff[a])),
      .quo (qa[a])
    );
  end

  // valid and signs ride alongside the dividers
  logic [DIV_LAT-1:0] val_a_r;
  logic [2:0]         neg_a_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_a_r <= '0;
    end else begin
      val_a_r <= {val_a_r[DIV_LAT-2:0], val0_r};
    end
  end

  always_ff @(posedge clk) begin
    neg_a_r[0] <= neg0_r;
    for (int d = 1; d < DIV_LAT; d++) begin
      neg_a_r[d] <= neg_a_r[d-1];
    end
  end

  // ---------------------------------------------------------------- leading-one search
  function automatic logic [POS_IDX_W-1:0] msb_pos(logic [CHUNK_W-1:0] w);
    logic [POS_IDX_W-1:0] p;
    p = '0;
    for (int b = 0; b < CHUNK_W; b++) begin
      if (w[b]) p = POS_IDX_W'(b);
    end
    return p;
  endfunction

  // stage 1: per-chunk leading one of the or of all three
  logic                      val1_r;
  logic [2:0]                neg1_r;
  logic [2:0][Q_W-1:0]       q1_r;
  logic [CHUNKS-1:0]         nz1_r;
  logic [POS_IDX_W-1:0]      pos1_r [CHUNKS];
  logic [Q_W-1:0]            qor;

  assign qor = qa[0][Q_W-1:0] | qa[1][Q_W-1:0] | qa[2][Q_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val1_r <= 1'b0;
    end else begin
      val1_r <= val_a_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    neg1_r <= neg_a_r[DIV_LAT-1];
    for (int i = 0; i < 3; i++) begin
      q1_r[i] <= qa[i][Q_W-1:0];
    end
    for (int j = 0; j < CHUNKS; j++) begin
      nz1_r[j]  <= qor[j*CHUNK_W +: CHUNK_W] != '0;
      pos1_r[j] <= msb_pos(qor[j*CHUNK_W +: CHUNK_W]);
    end
  end

  // stage 2: bit length of the largest component
  logic                val2_r;
  logic [2:0]          neg2_r;
  logic [2:0][Q_W-1:0] q2_r;
  logic [BL_W-1:0]     bl2_r;
  logic [BL_W-1:0]     bl_c;

  always_comb begin
    bl_c = '0;
    for (int j = 0; j < CHUNKS; j++) begin
      if (nz1_r[j]) bl_c = BL_W'(j * CHUNK_W) + BL_W'(pos1_r[j]) + BL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val2_r <= 1'b0;
    end else begin
      val2_r <= val1_r;
    end
  end

  always_ff @(posedge clk) begin
    neg2_r <= neg1_r;
    q2_r   <= q1_r;
    bl2_r  <= bl_c;
  end

  // stage 3: common shift so the largest has exactly V_W bits
  logic                val3_r;
  logic [2:0]          neg3_r;
  logic [2:0][V_W-1:0] v3_r;
  logic [BL_W-1:0]     bl3_r;
  logic [BL_W:0]       shamt;

  assign shamt = {1'b0, bl2_r} + (BL_W+1)'(NORM_W - V_W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val3_r <= 1'b0;
    end else begin
      val3_r <= val2_r;
    end
  end

  always_ff @(posedge clk) begin
    neg3_r <= neg2_r;
    bl3_r  <= bl2_r;
    for (int i = 0; i < 3; i++) begin
      v3_r[i] <= V_W'({q2_r[i], {NORM_W{1'b0}}} >> shamt);
    end
  end

  // ---------------------------------------------------------------- squares
  // stage 4: half-word partial products
  logic                     val4_r;
  logic [2:0]               neg4_r;
  logic [2:0][V_W-1:0]      v4_r;
  logic [BL_W-1:0]          bl4_r;
  logic [2:0][2*HALF_W-1:0] pll_r;
  logic [2:0][2*HALF_W-1:0] plh_r;
  logic [2:0][2*HALF_W-1:0] phh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val4_r <= 1'b0;
    end else begin
      val4_r <= val3_r;
    end
  end

  always_ff @(posedge clk) begin
    neg4_r <= neg3_r;
    v4_r   <= v3_r;
    bl4_r  <= bl3_r;
    for (int i = 0; i < 3; i++) begin
      pll_r[i] <= {{HALF_W{1'b0}}, v3_r[i][HALF_W-1:0]} *
                  {{HALF_W{1'b0}}, v3_r[i][HALF_W-1:0]};
      plh_r[i] <= {{HALF_W{1'b0}}, v3_r[i][HALF_W-1:0]} *
                  {{HALF_W{1'b0}}, v3_r[i][V_W-1:HALF_W]};
      phh_r[i] <= {{HALF_W{1'b0}}, v3_r[i][V_W-1:HALF_W]} *
                  {{HALF_W{1'b0}}, v3_r[i][V_W-1:HALF_W]};
    end
  end

  // stage 5: assemble the squares
  logic                 val5_r;
  logic [2:0]           neg5_r;
  logic [2:0][V_W-1:0]  v5_r;
  logic [BL_W-1:0]      bl5_r;
  logic [2:0][SQ_W-1:0] sq5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val5_r <= 1'b0;
    end else begin
      val5_r <= val4_r;
    end
  end

  always_ff @(posedge clk) begin
    neg5_r <= neg4_r;
    v5_r   <= v4_r;
    bl5_r  <= bl4_r;
    for (int i = 0; i < 3; i++) begin
      sq5_r[i] <= (SQ_W'(phh_r[i]) << (2 * HALF_W)) + (SQ_W'(plh_r[i]) << (HALF_W + 1)) +
                  SQ_W'(pll_r[i]);
    end
  end

  // stage 6: sums, unit-length threshold, inside and polar checks
  logic                val6_r;
  logic [2:0]          neg6_r;
  logic [2:0][V_W-1:0] v6_r;
  logic [BL_W:0]       lim6_r;
  status_t             status6_r;
  logic [SQ_W-1:0]     horiz6_r;
  logic [SQ_W-1:0]     sum6_r;
  logic [SQ_W-1:0]     rad6_r;
  logic [SQ_W-1:0]     horiz_c;
  logic [SQ_W-1:0]     sum_c;
  logic [BL_W:0]       lim_c;
  logic [SQ_W-1:0]     one_c;
  logic                inside_c;
  status_t             status_c;

  always_comb begin
    horiz_c  = sq5_r[0] + sq5_r[1];
    sum_c    = horiz_c + sq5_r[2];
    lim_c    = (BL_W+1)'(LIM_OFFS) - {1'b0, bl5_r};
    // one unit of u, squared
    one_c    = SQ_W'(1) << {lim_c, 1'b0};
    // far-ahead exponent, a zero position or a length under one unit counts as inside
    inside_c = (bl5_r <= BL_W'(V_W + 1)) || (sum_c < one_c);
    if (inside_c) begin
      status_c = ST_INSIDE;
    end else if (v5_r[0] == '0 && v5_r[1] == '0) begin
      status_c = ST_POLAR;
    end else begin
      status_c = ST_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val6_r <= 1'b0;
    end else begin
      val6_r <= val5_r;
    end
  end

  always_ff @(posedge clk) begin
    neg6_r    <= neg5_r;
    v6_r      <= v5_r;
    lim6_r    <= lim_c;
    status6_r <= status_c;
    horiz6_r  <= horiz_c;
    sum6_r    <= sum_c;
    rad6_r    <= sum_c - one_c;
  end

  // ---------------------------------------------------------------- square roots
  logic [ROOT_W-1:0] dv_root;
  logic [ROOT_W-1:0] h_root;
  logic [ROOT_W-1:0] wl_root;

  ehq_sqrt u_sqrt_len (.clk(clk), .x(sum6_r),   .root(dv_root));
  ehq_sqrt u_sqrt_hor (.clk(clk), .x(horiz6_r), .root(h_root));
  ehq_sqrt u_sqrt_lim (.clk(clk), .x(rad6_r),   .root(wl_root));

  typedef struct packed {
    logic [2:0]          neg;
    status_t             status;
    logic [2:0][V_W-1:0] v;
    logic [BL_W:0]       lim;
  } side_b_t;

  logic [SQRT_LAT-1:0] val_b_r;
  side_b_t             side_b_r [SQRT_LAT];
  side_b_t             side_b6;
  side_b_t             sb;

  assign side_b6 = '{neg: neg6_r, status: status6_r, v: v6_r, lim: lim6_r};
  assign sb      = side_b_r[SQRT_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_b_r <= '0;
    end else begin
      val_b_r <= {val_b_r[SQRT_LAT-2:0], val6_r};
    end
  end

  always_ff @(posedge clk) begin
    side_b_r[0] <= side_b6;
    for (int d = 1; d < SQRT_LAT; d++) begin
      side_b_r[d] <= side_b_r[d-1];
    end
  end

  // ---------------------------------------------------------------- unit quotients
  // a_i = v_i / |v|, e = (-vy, vx) / |vh|, s = limb / |v|, t = unit / |v|
  logic [DIV_W-1:0] num_t;
  logic [DIV_W-1:0] qd_a [3];
  logic [DIV_W-1:0] qd_e0;
  logic [DIV_W-1:0] qd_e1;
  logic [DIV_W-1:0] qd_s;
  logic [DIV_W-1:0] qd_t;

  // outside the valid case the shift could run past the word
  assign num_t = (sb.status == ST_VALID) ?
                 (DIV_W'(1) << (sb.lim + (BL_W+1)'(UNIT_FRAC))) : '0;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    ehq_div u_div (
      .clk (clk),
      .num (DIV_W'(sb.v[a]) << UNIT_FRAC),
      .den (DEN_W'(dv_root)),
      .quo (qd_a[a])
    );
  end

  ehq_div u_div_e0 (
    .clk (clk), .num (DIV_W'(sb.v[1]) << UNIT_FRAC), .den (DEN_W'(h_root)), .quo (qd_e0)
  );
  ehq_div u_div_e1 (
    .clk (clk), .num (DIV_W'(sb.v[0]) << UNIT_FRAC), .den (DEN_W'(h_root)), .quo (qd_e1)
  );
  ehq_div u_div_s (
    .clk (clk), .num (DIV_W'(wl_root) << UNIT_FRAC), .den (DEN_W'(dv_root)), .quo (qd_s)
  );
  ehq_div u_div_t (
    .clk (clk), .num (num_t), .den (DEN_W'(dv_root)), .quo (qd_t)
  );

  logic [DIV_LAT-1:0] val_c_r;
  logic [2:0]         neg_c_r    [DIV_LAT];
  status_t            status_c_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_c_r <= '0;
    end else begin
      val_c_r <= {val_c_r[DIV_LAT-2:0], val_b_r[SQRT_LAT-1]};
    end
  end

  always_ff @(posedge clk) begin
    neg_c_r[0]    <= sb.neg;
    status_c_r[0] <= sb.status;
    for (int d = 1; d < DIV_LAT; d++) begin
      neg_c_r[d]    <= neg_c_r[d-1];
      status_c_r[d] <= status_c_r[d-1];
    end
  end

  // stage 8: signed unit values
  logic    val8_r;
  status_t status8_r;
  unit_t   a8_r [3];
  unit_t   e8_r [2];
  unit_t   s8_r;
  unit_t   t8_r;
  logic [2:0] negc;

  assign negc = neg_c_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val8_r <= 1'b0;
    end else begin
      val8_r <= val_c_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    status8_r <= status_c_r[DIV_LAT-1];
    for (int i = 0; i < 3; i++) begin
      a8_r[i] <= to_unit(qd_a[i], negc[i]);
    end
    e8_r[0] <= to_unit(qd_e0, !negc[1]);
    e8_r[1] <= to_unit(qd_e1, negc[0]);
    s8_r    <= to_unit(qd_s, 1'b0);
    t8_r    <= to_unit(qd_t, 1'b0);
  end

  // stage 9: north vector n = a x e and limb center c = a * t
  logic    val9_r;
  status_t status9_r;
  unit_t   n9_r   [3];
  unit_t   cen9_r [3];
  unit_t   e9_r   [2];
  unit_t   s9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val9_r <= 1'b0;
    end else begin
      val9_r <= val8_r;
    end
  end

  always_ff @(posedge clk) begin
    status9_r <= status8_r;
    n9_r[0]   <= -qmul(a8_r[2], e8_r[1]);
    n9_r[1]   <= qmul(a8_r[2], e8_r[0]);
    n9_r[2]   <= qmul(a8_r[0], e8_r[1]) - qmul(a8_r[1], e8_r[0]);
    for (int i = 0; i < 3; i++) begin
      cen9_r[i] <= qmul(a8_r[i], t8_r);
    end
    e9_r <= e8_r;
    s9_r <= s8_r;
  end

  // stage 10: half-extent offsets along north and east
  logic    val10_r;
  status_t status10_r;
  unit_t   cen10_r [3];
  unit_t   sn10_r  [3];
  unit_t   se10_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val10_r <= 1'b0;
    end else begin
      val10_r <= val9_r;
    end
  end

  always_ff @(posedge clk) begin
    status10_r <= status9_r;
    cen10_r    <= cen9_r;
    for (int i = 0; i < 3; i++) begin
      sn10_r[i] <= qmul(s9_r, n9_r[i]);
    end
    se10_r[0] <= qmul(s9_r, e9_r[0]);
    se10_r[1] <= qmul(s9_r, e9_r[1]);
    se10_r[2] <= '0;
  end

  // ---------------------------------------------------------------- corner sequencer
  // items reach here no closer together than the intake lets them in, so the hold copy is
  // free again by the time the next item lands
  logic       emit_r;
  logic       emit_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       fin;
  status_t    hstat_r;
  unit_t      hcen_r [3];
  unit_t      hsn_r  [3];
  unit_t      hse_r  [3];

  assign fin = (cnt_r == 2'd3) || (hstat_r != ST_VALID);

  always_comb begin
    emit_nxt = emit_r;
    cnt_nxt  = cnt_r;
    if (val10_r) begin
      emit_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (emit_r) begin
      if (fin) begin
        emit_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      emit_r <= emit_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (val10_r) begin
      hstat_r <= status10_r;
      hcen_r  <= cen10_r;
      hsn_r   <= sn10_r;
      hse_r   <= se10_r;
    end
  end

  // stage 11: corner offsets, bit 0 of the corner flips north, bit 1 flips east
  logic                 kval_r;
  logic [1:0]           kcorner_r;
  logic                 klast_r;
  status_t              kstat_r;
  logic signed [K_W-1:0] k_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kval_r <= 1'b0;
    end else begin
      kval_r <= emit_r;
    end
  end

  always_ff @(posedge clk) begin
    kcorner_r <= (hstat_r == ST_VALID) ? cnt_r : 2'd0;
    klast_r   <= fin;
    kstat_r   <= hstat_r;
    for (int i = 0; i < 3; i++) begin
      if (hstat_r != ST_VALID) begin
        k_r[i] <= '0;
      end else begin
        k_r[i] <= K_W'(hcen_r[i]) +
                  (cnt_r[0] ? -K_W'(hsn_r[i]) : K_W'(hsn_r[i])) +
                  (cnt_r[1] ? K_W'(hse_r[i]) : -K_W'(hse_r[i]));
      end
    end
  end

  // stage 12: back to millimetres, saturated
  localparam int PROD_W = K_W + RAD_W;
  localparam int SAT_W  = PROD_W + POS_W;

  logic [POS_W-1:0] vert_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic              kneg;
      logic [K_W-1:0]    mk;
      logic [PROD_W-1:0] prod;
      logic [SAT_W-1:0]  m;
      logic [SAT_W-1:0]  bound;
      logic [POS_W-1:0]  v;
      kneg  = k_r[i][K_W-1];
      mk    = kneg ? K_W'(-k_r[i]) : K_W'(k_r[i]);
      prod  = {{RAD_W{1'b0}}, mk} * {{K_W{1'b0}}, reff[i]};
      m     = SAT_W'(prod >> UNIT_FRAC);
      bound = (SAT_W'(1) << (POS_W - 1)) - (kneg ? SAT_W'(0) : SAT_W'(1));
      v     = (m > bound) ? POS_W'(bound) : POS_W'(m);
      vert_c[i] = kneg ? (~v + 1'b1) : v;
    end
  end

  logic      out_valid_r;
  out_beat_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= kval_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.corner   <= kcorner_r;
    out_data_r.vertex_x <= vert_c[0];
    out_data_r.vertex_y <= vert_c[1];
    out_data_r.vertex_z <= vert_c[2];
    out_data_r.status   <= kstat_r;
    out_data_r.last     <= klast_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[hw/rtl/ehq_div.sv]
`default_nettype none

module ehq_div (
  input  logic                       clk,
  input  logic [ehq_pkg::DIV_W-1:0]  num,
  input  logic [ehq_pkg::DEN_W-1:0]  den,
  output logic [ehq_pkg::DIV_W-1:0]  quo
);
  import ehq_pkg::*;

  logic [DIV_W-1:0] num_r [DIV_LAT];
  logic [DEN_W-1:0] den_r [DIV_LAT];
  logic [DEN_W-1:0] rem_r [DIV_LAT];
  logic [DIV_W-1:0] quo_r [DIV_LAT];

  // one quotient bit per stage
  for (genvar g = 0; g < DIV_LAT; g++) begin : g_step
    logic [DIV_W-1:0] num_in;
    logic [DIV_W-1:0] quo_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W:0]   trial;
    logic             take;

    if (g == 0) begin : g_first
      assign num_in = num;
      assign den_in = den;
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign num_in = num_r[g-1];
      assign den_in = den_r[g-1];
      assign rem_in = rem_r[g-1];
      assign quo_in = quo_r[g-1];
    end

    assign trial = {rem_in, num_in[DIV_W-1]};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      num_r[g] <= {num_in[DIV_W-2:0], 1'b0};
      den_r[g] <= den_in;
      rem_r[g] <= take ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
      quo_r[g] <= {quo_in[DIV_W-2:0], take};
    end
  end

  assign quo = quo_r[DIV_LAT-1];

endmodule

`default_nettype wire

[hw/rtl/ehq_sqrt.sv]
`default_nettype none

module ehq_sqrt (
  input  logic                       clk,
  input  logic [ehq_pkg::SQ_W-1:0]   x,
  output logic [ehq_pkg::ROOT_W-1:0] root
);
  import ehq_pkg::*;

  localparam int REM_W = ROOT_W + 2;
  localparam int SH_W  = ROOT_W + 4;

  logic [SQ_W-1:0]   x_r    [SQRT_LAT];
  logic [REM_W-1:0]  rem_r  [SQRT_LAT];
  logic [ROOT_W-1:0] root_r [SQRT_LAT];

  // one root bit per stage, restoring form
  for (genvar g = 0; g < SQRT_LAT; g++) begin : g_step
    logic [SQ_W-1:0]   x_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SH_W-1:0]   sh;
    logic [SH_W-1:0]   trial;
    logic              take;

    if (g == 0) begin : g_first
      assign x_in    = x;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign x_in    = x_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
    end

    assign sh    = {rem_in, x_in[SQ_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign take  = sh >= trial;

    always_ff @(posedge clk) begin
      x_r[g]    <= {x_in[SQ_W-3:0], 2'b00};
      rem_r[g]  <= take ? REM_W'(sh - trial) : REM_W'(sh);
      root_r[g] <= {root_in[ROOT_W-2:0], take};
    end
  end

  assign root = root_r[SQRT_LAT-1];

endmodule

`default_nettype wire

[hw/rtl/ehq_checker.sv]
`default_nettype none

`include "ellipsoid_horizon_quad_unit_defines.svh"

module ehq_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               out_valid,
  input  ehq_pkg::out_beat_t out_data
);
  import ehq_pkg::*;

  logic       more_beats;
  logic       flagged;
  logic       quad_end;
  logic [1:0] corner_next;

  assign more_beats  = out_valid && !out_data.last;
  assign flagged     = out_valid && out_data.status != ST_VALID;
  assign quad_end    = out_valid && out_data.last && out_data.status == ST_VALID;
  assign corner_next = out_data.corner + 2'd1;

  // a taken item blocks the next one for a while
  `EHQ_ASSERT_NEXT(a_busy_after_take, start && !busy, busy)

  // beats of one quad come back to back with rising corner number
  `EHQ_ASSERT_NEXT(a_corner_step, more_beats, out_valid && out_data.corner == $past(corner_next))

  // flagged items give a single beat at corner zero
  `EHQ_ASSERT_IMPL(a_flag_single, flagged, out_data.last && out_data.corner == 2'd0)

  // a full quad ends on the lower right corner
  `EHQ_ASSERT_IMPL(a_quad_end, quad_end, out_data.corner == 2'd3)

endmodule

bind ellipsoid_horizon_quad_unit ehq_checker u_ehq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire

[tb/tb_ellipsoid_horizon_quad_unit.sv]
`default_nettype none

module tb_ellipsoid_horizon_quad_unit;
  import ehq_pkg::*;

  localparam int  LATENCY_WAIT = 500;      // well past the pipeline depth
  localparam int  CYCLE_LIMIT  = 1500000;
  localparam int  ITEMS_PHASE  = 75;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  in_beat_t           in_data = '0;
  logic               out_valid;
  out_beat_t          out_data;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_RADIUS_X;
  logic [RAD_W-1:0]   cfg_wdata = '0;

  int unsigned        cycles = 0;
  int                 idle_pct = 0;
  logic [RAD_W-1:0]   rad_now [3];

  // scoreboard: horizon quad predictor plus the queue of corners still owed
  class horizon_board;
    out_beat_t     owed [$];
    logic [63:0]   radius [3];
    int            errors = 0;

    function new();
      radius[0] = 64'(RADIUS_X_RST);
      radius[1] = 64'(RADIUS_Y_RST);
      radius[2] = 64'(RADIUS_Z_RST);
    endfunction

    function void set_radius(int idx, logic [RAD_W-1:0] val);
      radius[idx] = 64'(val);
    endfunction

    task report(string msg);
      $display("ERROR at cycle %0d: %s", cycles, msg);
      errors++;
    endtask

    // append one expected beat at the tail
    function void owe(out_beat_t o);
      owed = {owed, o};
    endfunction

    function int bit_len(logic [127:0] x);
      for (int i = 127; i >= 0; i--) if (x[i]) return i + 1;
      return 0;
    endfunction

    function logic [63:0] root(logic [127:0] x);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (128'(c) * 128'(c) <= x) r = c;
      end
      return r;
    endfunction

    // (mag << F) / den with the sign put on afterwards
    function longint unit_quot(logic [63:0] mag, bit neg, logic [63:0] den);
      logic [127:0] qt;
      longint m;
      qt = (128'(mag) << UNIT_FRAC) / 128'(den);
      m = longint'(qt[63:0]);
      return neg ? -m : m;
    endfunction

    function longint fx_mul(longint x, longint y);
      logic [63:0]  mx;
      logic [63:0]  my;
      logic [127:0] p;
      longint m;
      mx = x < 0 ? 64'(-x) : 64'(x);
      my = y < 0 ? 64'(-y) : 64'(y);
      p = (128'(mx) * 128'(my)) >> UNIT_FRAC;
      m = longint'(p[63:0]);
      return ((x < 0) != (y < 0)) ? -m : m;
    endfunction

    function logic [POS_W-1:0] to_mm(longint k, logic [63:0] r);
      logic [63:0]  mk;
      logic [127:0] m;
      logic [63:0]  bound;
      logic [63:0]  v;
      mk = k < 0 ? 64'(-k) : 64'(k);
      m = (128'(mk) * 128'(r)) >> UNIT_FRAC;
      bound = (64'd1 << (POS_W - 1)) - ((k < 0) ? 64'd0 : 64'd1);
      v = (m[127:64] != 0 || m[63:0] > bound) ? bound : m[63:0];
      return (k < 0) ? POS_W'(64'd0 - v) : POS_W'(v);
    endfunction

    function void flag_only(status_t st);
      out_beat_t o;
      o = '0;
      o.status = st;
      o.last = 1'b1;
      owe(o);
    endfunction

    // accepted camera position: work out its corners
    function void note_camera(in_beat_t b);
      logic [63:0]  r [3];
      logic [63:0]  mag [3];
      bit           neg [3];
      logic [127:0] q [3];
      logic [63:0]  v [3];
      logic [63:0]  coord;
      logic [127:0] horiz;
      logic [127:0] sum;
      logic [127:0] unit_sq;
      logic [127:0] tq;
      logic [63:0]  dv;
      logic [63:0]  h;
      logic [63:0]  wl;
      int           bl;
      int           lexp;
      longint       a [3];
      longint       e [3];
      longint       n [3];
      longint       cen [3];
      longint       sn [3];
      longint       se [3];
      longint       s;
      longint       t;
      longint       k;
      out_beat_t    o;
      logic [POS_W-1:0] vert [3];
      bl = 0;
      for (int i = 0; i < 3; i++) begin
        coord = (i == 0) ? 64'(b.camera_x) : (i == 1) ? 64'(b.camera_y) : 64'(b.camera_z);
        r[i] = (radius[i] == 0) ? 64'd1 : radius[i];
        neg[i] = coord[63];
        mag[i] = neg[i] ? 64'd0 - coord : coord;
        q[i] = {mag[i], 64'd0} / 128'(r[i]);
        if (bit_len(q[i]) > bl) bl = bit_len(q[i]);
      end
      if (bl == 0) begin
        flag_only(ST_INSIDE);
        return;
      end
      for (int i = 0; i < 3; i++)
        v[i] = bl > 62 ? 64'(q[i] >> (bl - 62)) : 64'(q[i] << (62 - bl));
      lexp = 126 - bl;
      horiz = 128'(v[0]) * 128'(v[0]) + 128'(v[1]) * 128'(v[1]);
      sum = horiz + 128'(v[2]) * 128'(v[2]);
      unit_sq = (lexp >= 0 && lexp < 63) ? (128'd1 << (2 * lexp)) : '0;
      if (lexp >= 63 || (lexp >= 0 && sum < unit_sq)) begin
        flag_only(ST_INSIDE);
        return;
      end
      if (v[0] == 0 && v[1] == 0) begin
        flag_only(ST_POLAR);
        return;
      end
      dv = root(sum);
      h = root(horiz);
      wl = root(lexp >= 0 ? sum - unit_sq : sum);
      s = unit_quot(wl, 1'b0, dv);
      tq = (128'd1 << (lexp + UNIT_FRAC)) / 128'(dv);
      t = longint'(tq[63:0]);
      for (int i = 0; i < 3; i++) a[i] = unit_quot(v[i], neg[i], dv);
      // east = z x u, normalized over the horizontal length
      e[0] = unit_quot(v[1], !neg[1], h);
      e[1] = unit_quot(v[0], neg[0], h);
      e[2] = 0;
      n[0] = -fx_mul(a[2], e[1]);
      n[1] = fx_mul(a[2], e[0]);
      n[2] = fx_mul(a[0], e[1]) - fx_mul(a[1], e[0]);
      for (int i = 0; i < 3; i++) begin
        cen[i] = fx_mul(a[i], t);
        sn[i] = fx_mul(s, n[i]);
        se[i] = fx_mul(s, e[i]);
      end
      for (int c = 0; c < 4; c++) begin
        for (int i = 0; i < 3; i++) begin
          k = cen[i] + (c[0] ? -sn[i] : sn[i]) + (c[1] ? se[i] : -se[i]);
          vert[i] = to_mm(k, r[i]);
        end
        o.corner = 2'(c);
        o.vertex_x = vert[0];
        o.vertex_y = vert[1];
        o.vertex_z = vert[2];
        o.status = ST_VALID;
        o.last = (c == 3);
        owe(o);
      end
    endfunction

    task check_corner(out_beat_t got);
      out_beat_t want;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result beat %p", got));
        return;
      end
      want = owed.pop_front();
      if (got.corner !== want.corner)
        report($sformatf("corner %0d, want %0d", got.corner, want.corner));
      if (got.vertex_x !== want.vertex_x)
        report($sformatf("vertex_x %0d, want %0d", got.vertex_x, want.vertex_x));
      if (got.vertex_y !== want.vertex_y)
        report($sformatf("vertex_y %0d, want %0d", got.vertex_y, want.vertex_y));
      if (got.vertex_z !== want.vertex_z)
        report($sformatf("vertex_z %0d, want %0d", got.vertex_z, want.vertex_z));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  horizon_board board = new();

  ellipsoid_horizon_quad_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // result beats can't be held off, so every strobe is checked on the spot
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_corner(out_data);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // one radius write, only ever issued while the block is drained
  task write_radius(logic [CFG_IDX_W-1:0] idx, logic [RAD_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_radius(int'(idx), val);
    rad_now[idx] = val;
  endtask

  // hold start until the block takes the beat, then maybe idle for a while
  task send_camera(in_beat_t b);
    start <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
    board.note_camera(b);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // stop driving and let every owed corner drain out, then settle
  task drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  function automatic logic [POS_W-1:0] rand_pos();
    return POS_W'({$urandom, $urandom});
  endfunction

  // signed value within +-lim, lim at most the position range
  function automatic logic [POS_W-1:0] rand_within(logic [63:0] lim);
    logic [63:0] span;
    logic [63:0] raw;
    span = 2 * lim + 1;
    raw = {$urandom, $urandom} % span;
    return POS_W'(raw - lim);
  endfunction

  function automatic in_beat_t rand_camera();
    in_beat_t  b;
    logic [63:0] lim;
    int        pick;
    int        ax;
    logic [63:0] big_r;
    pick = $urandom_range(99);
    big_r = rad_now[0] > rad_now[2] ? rad_now[0] : rad_now[2];
    lim = 4 * 64'(big_r) + 16;
    if (lim > 64'h7FFF_FFFF_FFFF) lim = 64'h7FFF_FFFF_FFFF;
    if (pick < 55) begin
      // around the ellipsoid, a few radii out: the well-behaved horizon case
      b.camera_x = rand_within(lim);
      b.camera_y = rand_within(lim);
      b.camera_z = rand_within(lim);
    end else if (pick < 75) begin
      b.camera_x = rand_pos();
      b.camera_y = rand_pos();
      b.camera_z = rand_pos();
    end else if (pick < 85) begin
      // near the middle, mostly inside
      b.camera_x = rand_within(64'(rad_now[0]) / 2 + 1);
      b.camera_y = rand_within(64'(rad_now[1]) / 2 + 1);
      b.camera_z = rand_within(64'(rad_now[2]) / 2 + 1);
    end else if (pick < 93) begin
      // on or just off the polar axis
      b.camera_x = $urandom_range(1) ? '0 : rand_within(3);
      b.camera_y = $urandom_range(1) ? '0 : rand_within(3);
      b.camera_z = rand_pos();
    end else begin
      // on the surface along one axis
      b = '0;
      ax = $urandom_range(2);
      if (ax == 0) b.camera_x = $urandom_range(1) ? POS_W'(rad_now[0]) : -POS_W'(rad_now[0]);
      else if (ax == 1) b.camera_y = $urandom_range(1) ? POS_W'(rad_now[1]) : -POS_W'(rad_now[1]);
      else b.camera_z = $urandom_range(1) ? POS_W'(rad_now[2]) : -POS_W'(rad_now[2]);
    end
    return b;
  endfunction

  task run_random(int count, int pct);
    idle_pct = pct;
    repeat (count) send_camera(rand_camera());
  endtask

  localparam logic [POS_W-1:0] PMAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] PMIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [RAD_W-1:0] RMAX = '1;

  initial begin
    rad_now[0] = RADIUS_X_RST;
    rad_now[1] = RADIUS_Y_RST;
    rad_now[2] = RADIUS_Z_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats at the reset radii
    idle_pct = 0;
    send_camera('{camera_x: '0, camera_y: '0, camera_z: '0});            // origin, inside
    send_camera('{camera_x: '0, camera_y: '0, camera_z: PMAX});          // polar, north
    send_camera('{camera_x: '0, camera_y: '0, camera_z: PMIN});          // polar, south
    send_camera('{camera_x: PMAX, camera_y: PMAX, camera_z: PMAX});
    send_camera('{camera_x: PMIN, camera_y: PMIN, camera_z: PMIN});
    send_camera('{camera_x: PMAX, camera_y: PMIN, camera_z: '0});
    send_camera('{camera_x: PMIN, camera_y: PMAX, camera_z: 48'sd1});
    send_camera('{camera_x: 48'sd6378137000, camera_y: '0, camera_z: '0}); // on surface
    send_camera('{camera_x: -48'sd6378137000, camera_y: '0, camera_z: '0});
    send_camera('{camera_x: '0, camera_y: 48'sd6378136999, camera_z: '0}); // just inside
    send_camera('{camera_x: 48'sd12756274000, camera_y: 48'sd1, camera_z: 48'sd5});
    send_camera('{camera_x: 48'sd1, camera_y: '0, camera_z: PMAX});      // just off the polar axis
    send_camera('{camera_x: -48'sd1, camera_y: -48'sd1, camera_z: '0});  // tiny, inside
    send_camera('{camera_x: 48'sd7000000000, camera_y: -48'sd7000000000,
                  camera_z: -48'sd7000000000});
    send_camera('{camera_x: 48'sd5555555555, camera_y: 48'sd4444444444,
                  camera_z: 48'sd3333333333});
    send_camera('{camera_x: 48'h555555555555, camera_y: 48'haaaaaaaaaaaa,
                  camera_z: 48'h0f0f0f0f0f0f});
    drain();

    // smallest radii: every camera off the origin is at least one radius out
    write_radius(REG_RADIUS_X, RAD_W'(1));
    write_radius(REG_RADIUS_Y, RAD_W'(1));
    write_radius(REG_RADIUS_Z, RAD_W'(1));
    send_camera('{camera_x: PMAX, camera_y: PMIN, camera_z: PMAX});
    send_camera('{camera_x: 48'sd1, camera_y: '0, camera_z: '0});
    send_camera('{camera_x: 48'sd1, camera_y: 48'sd1, camera_z: 48'sd1});
    run_random(ITEMS_PHASE - 3, 0);
    drain();

    // largest radii, sender idling often
    write_radius(REG_RADIUS_X, RMAX);
    write_radius(REG_RADIUS_Y, RMAX);
    write_radius(REG_RADIUS_Z, RMAX);
    send_camera('{camera_x: PMAX, camera_y: PMAX, camera_z: PMAX});
    run_random(ITEMS_PHASE, 63);
    drain();

    // a zero radius acts as one; mixed extremes
    write_radius(REG_RADIUS_X, RAD_W'(0));
    write_radius(REG_RADIUS_Y, RMAX);
    write_radius(REG_RADIUS_Z, RAD_W'($urandom_range(1000, 2000000)));
    run_random(ITEMS_PHASE / 2, 22);
    drain();

    // random radii, light idling
    write_radius(REG_RADIUS_X, RAD_W'({$urandom, $urandom}));
    write_radius(REG_RADIUS_Y, RAD_W'({$urandom, $urandom}));
    write_radius(REG_RADIUS_Z, RAD_W'({$urandom, $urandom}));
    run_random(ITEMS_PHASE, 22);
    drain();

    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+hw/rtl
hw/rtl/ehq_pkg.sv
hw/rtl/ehq_div.sv
hw/rtl/ehq_sqrt.sv
hw/rtl/ellipsoid_horizon_quad_unit.sv
hw/rtl/ehq_checker.sv
tb/tb_ellipsoid_horizon_quad_unit.sv
